@@ rtl/core/x86_instruction_encoder_macros.svh @@
// assertion macros for the x86 instruction encoder
`ifndef X86_INSTRUCTION_ENCODER_MACROS_SVH
`define X86_INSTRUCTION_ENCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define X86E_ASSERT_IMP(lbl, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define X86E_ASSERT_NXT(lbl, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define X86E_ASSERT_IMP(lbl, rst_n, a, b)
`define X86E_ASSERT_NXT(lbl, rst_n, a, b)
`endif
`endif

@@ rtl/core/x86e_pkg.sv @@
// shared types and constants for the x86 instruction encoder
`default_nettype none
package x86e_pkg;
  localparam int MaxBytes = 12;
  localparam int QDepth = 4;

  typedef struct packed {
    logic [5:0]  func;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [31:0] imm_value;
    logic [31:0] offset_value;
    logic [3:0]  cond_code;
    logic [7:0]  src_rex;
    logic [7:0]  src_modrm;
    logic [7:0]  src_sib;
    logic        src_sib_present;
    logic [1:0]  src_disp_size;
    logic        src_rip_relative;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] byte_index;
    logic       last_byte;
  } out_item_t;

  // one fully built instruction, bytes in memory order
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [3:0]               len;
  } enc_t;

  // instruction form selectors
  localparam logic [5:0] FnMovRR     = 6'd0;
  localparam logic [5:0] FnStoreSlot = 6'd1;
  localparam logic [5:0] FnLoadSlot  = 6'd2;
  localparam logic [5:0] FnLea       = 6'd3;
  localparam logic [5:0] FnMovExpr   = 6'd4;
  localparam logic [5:0] FnPush      = 6'd5;
  localparam logic [5:0] FnPop       = 6'd6;
  localparam logic [5:0] FnCall      = 6'd7;
  localparam logic [5:0] FnCallReg   = 6'd8;
  localparam logic [5:0] FnSubImm    = 6'd9;
  localparam logic [5:0] FnCmpImm    = 6'd10;
  localparam logic [5:0] FnJcc       = 6'd11;
  localparam logic [5:0] FnRet       = 6'd12;
  localparam logic [5:0] FnXchgSp    = 6'd13;
  localparam logic [5:0] FnMovImm    = 6'd14;
  localparam logic [5:0] FnMovImmMem = 6'd15;
  localparam logic [5:0] FnOrImmMem  = 6'd16;
  localparam logic [5:0] FnTest      = 6'd17;
  localparam logic [5:0] FnJmpInner  = 6'd18;
  localparam logic [5:0] FnJmpExt    = 6'd19;
  localparam logic [5:0] FnMovEsp    = 6'd20;
  localparam logic [5:0] FnXchgEsp   = 6'd21;
  localparam logic [5:0] FnJmpMem    = 6'd22;
  localparam logic [5:0] FnXchg      = 6'd23;
  localparam logic [5:0] FnPushf     = 6'd24;
  localparam logic [5:0] FnPopf      = 6'd25;
  localparam logic [5:0] FnSub       = 6'd26;
  localparam logic [5:0] FnAddImm8   = 6'd27;
  localparam logic [5:0] FnNeg       = 6'd28;
  localparam logic [5:0] FnAddSlot   = 6'd29;
  localparam logic [5:0] FnAddBx     = 6'd30;
  localparam logic [5:0] FnMovzx     = 6'd31;
  localparam logic [5:0] FnUd2       = 6'd32;

  localparam logic [7:0] RexW    = 8'h48;
  localparam logic [7:0] RexR    = 8'h44;
  localparam logic [7:0] RexB    = 8'h41;
  localparam logic [7:0] RexRWX  = 8'h4C;
  localparam logic [7:0] RexNoR  = 8'hFB;
  localparam logic [7:0] SibSp   = 8'h24;
  localparam logic [7:0] OpLea   = 8'h8D;
  localparam logic [7:0] OpLoad  = 8'h8B;
  localparam logic [7:0] OpStore = 8'h89;
  localparam logic [7:0] OpCall  = 8'hE8;
  localparam logic [7:0] OpMovI  = 8'hC7;
endpackage
`default_nettype wire

@@ rtl/core/x86e_front.sv @@
// front end: classifies a form and builds its byte string into one word
`default_nettype none
module x86e_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              long_mode,
  input  wire logic              in_valid,
  input  wire x86e_pkg::in_item_t in_data,
  output x86e_pkg::enc_t         enc_data,
  output logic                   enc_valid
);
  x86e_pkg::enc_t enc_r, enc_nxt;
  logic           vld_r, vld_nxt;

  always_comb begin
    logic [3:0]  r1, r2;
    logic [7:0]  rx, slot_off, disp8;
    logic [31:0] disp;
    logic [3:0]  n;
    logic        w;
    r1 = in_data.first_reg;
    r2 = in_data.second_reg;
    n  = 4'd0;
    rx = 8'h00;
    w  = 1'b0;
    disp = in_data.offset_value;
    slot_off = long_mode ? {1'b0, r1, 3'b000} : {2'b00, r1, 2'b00};
    disp8 = 8'h00;
    enc_nxt.bytes = '0;
    // append helpers written inline over a running count
    case (in_data.func)
      x86e_pkg::FnMovRR, x86e_pkg::FnTest, x86e_pkg::FnXchg, x86e_pkg::FnSub: begin
        logic [3:0] b;
        logic [7:0] op;
        b = (in_data.func == x86e_pkg::FnTest) ? r1 : r2;
        case (in_data.func)
          x86e_pkg::FnMovRR: op = x86e_pkg::OpStore;
          x86e_pkg::FnTest:  op = 8'h85;
          x86e_pkg::FnXchg:  op = 8'h87;
          default:           op = 8'h29;
        endcase
        if (long_mode) begin
          enc_nxt.bytes[n] = x86e_pkg::RexW | (r1[3] ? x86e_pkg::RexR : 8'h00)
                             | (b[3] ? x86e_pkg::RexB : 8'h00);
          n = n + 4'd1;
        end
        enc_nxt.bytes[n] = op; n = n + 4'd1;
        enc_nxt.bytes[n] = {2'b11, r1[2:0], b[2:0]}; n = n + 4'd1;
      end
      x86e_pkg::FnStoreSlot, x86e_pkg::FnLoadSlot, x86e_pkg::FnAddSlot: begin
        logic [2:0] rf;
        rf = (in_data.func == x86e_pkg::FnAddSlot) ? 3'd0 : r1[2:0];
        if (long_mode) begin
          enc_nxt.bytes[n] = x86e_pkg::RexW
            | ((in_data.func != x86e_pkg::FnAddSlot && r1[3]) ? x86e_pkg::RexR : 8'h00)
            | (r2[3] ? x86e_pkg::RexB : 8'h00);
          n = n + 4'd1;
        end
        case (in_data.func)
          x86e_pkg::FnStoreSlot: enc_nxt.bytes[n] = x86e_pkg::OpStore;
          x86e_pkg::FnLoadSlot:  enc_nxt.bytes[n] = x86e_pkg::OpLoad;
          default:               enc_nxt.bytes[n] = 8'h03;
        endcase
        n = n + 4'd1;
        enc_nxt.bytes[n] = {2'b01, rf, r2[2:0]}; n = n + 4'd1;
        if (r2[2:0] == 3'd4) begin
          enc_nxt.bytes[n] = x86e_pkg::SibSp; n = n + 4'd1;
        end
        enc_nxt.bytes[n] = (in_data.func == x86e_pkg::FnAddSlot) ?
                           (long_mode ? 8'd24 : 8'd12) : slot_off;
        n = n + 4'd1;
      end
      x86e_pkg::FnLea, x86e_pkg::FnMovExpr: begin
        if (long_mode) begin
          rx = in_data.src_rex | x86e_pkg::RexRWX;
          if (!r1[3]) rx = rx & x86e_pkg::RexNoR;
          enc_nxt.bytes[n] = rx; n = n + 4'd1;
          if (in_data.src_rip_relative) disp = 32'h0;
        end
        enc_nxt.bytes[n] = (in_data.func == x86e_pkg::FnLea) ? x86e_pkg::OpLea
                                                              : x86e_pkg::OpLoad;
        n = n + 4'd1;
        enc_nxt.bytes[n] = {in_data.src_modrm[7:6], r1[2:0], in_data.src_modrm[2:0]};
        n = n + 4'd1;
        if (in_data.src_sib_present) begin
          enc_nxt.bytes[n] = in_data.src_sib; n = n + 4'd1;
        end
        if (in_data.src_disp_size == 2'd1) begin
          enc_nxt.bytes[n] = disp[7:0]; n = n + 4'd1;
        end else if (in_data.src_disp_size == 2'd2) begin
          for (int i = 0; i < 4; i++) begin
            enc_nxt.bytes[n] = disp[8*i +: 8]; n = n + 4'd1;
          end
        end
      end
      x86e_pkg::FnPush, x86e_pkg::FnPop, x86e_pkg::FnCallReg: begin
        if (long_mode && r1[3]) begin
          enc_nxt.bytes[n] = x86e_pkg::RexB; n = n + 4'd1;
        end
        case (in_data.func)
          x86e_pkg::FnPush: begin
            enc_nxt.bytes[n] = {5'b01010, r1[2:0]}; n = n + 4'd1;
          end
          x86e_pkg::FnPop: begin
            enc_nxt.bytes[n] = {5'b01011, r1[2:0]}; n = n + 4'd1;
          end
          default: begin
            enc_nxt.bytes[n] = 8'hFF; n = n + 4'd1;
            enc_nxt.bytes[n] = {5'b11010, r1[2:0]}; n = n + 4'd1;
          end
        endcase
      end
      x86e_pkg::FnCall, x86e_pkg::FnJmpInner, x86e_pkg::FnJmpExt: begin
        enc_nxt.bytes[0] = (in_data.func == x86e_pkg::FnCall) ? x86e_pkg::OpCall : 8'hE9;
        n = 4'd5;
      end
      x86e_pkg::FnSubImm, x86e_pkg::FnCmpImm: begin
        if (long_mode) begin enc_nxt.bytes[n] = x86e_pkg::RexW; n = n + 4'd1; end
        enc_nxt.bytes[n] = (in_data.func == x86e_pkg::FnSubImm) ? 8'h2D : 8'h3D;
        n = n + 4'd1;
        for (int i = 0; i < 4; i++) begin
          enc_nxt.bytes[n] = in_data.imm_value[8*i +: 8]; n = n + 4'd1;
        end
      end
      x86e_pkg::FnJcc: begin
        enc_nxt.bytes[0] = 8'h0F;
        enc_nxt.bytes[1] = {4'h8, in_data.cond_code};
        n = 4'd6;
      end
      x86e_pkg::FnRet: begin enc_nxt.bytes[0] = 8'hC3; n = 4'd1; end
      x86e_pkg::FnXchgSp: begin
        if (long_mode) begin enc_nxt.bytes[n] = x86e_pkg::RexW; n = n + 4'd1; end
        enc_nxt.bytes[n] = 8'h87; n = n + 4'd1;
        enc_nxt.bytes[n] = 8'h04; n = n + 4'd1;
        enc_nxt.bytes[n] = 8'h24; n = n + 4'd1;
      end
      x86e_pkg::FnMovImm: begin
        if (long_mode) begin
          enc_nxt.bytes[0] = x86e_pkg::RexW;
          enc_nxt.bytes[1] = x86e_pkg::OpMovI;
          enc_nxt.bytes[2] = 8'hC0;
          n = 4'd3;
        end else begin
          enc_nxt.bytes[0] = 8'hB8; n = 4'd1;
        end
        for (int i = 0; i < 4; i++) begin
          enc_nxt.bytes[n] = in_data.imm_value[8*i +: 8]; n = n + 4'd1;
        end
      end
      x86e_pkg::FnMovImmMem, x86e_pkg::FnOrImmMem, x86e_pkg::FnJmpMem: begin
        logic [2:0] rf;
        case (in_data.func)
          x86e_pkg::FnMovImmMem: rf = 3'd0;
          x86e_pkg::FnOrImmMem:  rf = 3'd1;
          default:               rf = 3'd4;
        endcase
        w = (in_data.func != x86e_pkg::FnJmpMem);
        if (long_mode && (w || r2[3])) begin
          enc_nxt.bytes[n] = (w ? x86e_pkg::RexW : 8'h00) | (r2[3] ? x86e_pkg::RexB : 8'h00);
          n = n + 4'd1;
        end
        case (in_data.func)
          x86e_pkg::FnMovImmMem: enc_nxt.bytes[n] = x86e_pkg::OpMovI;
          x86e_pkg::FnOrImmMem:  enc_nxt.bytes[n] = 8'h81;
          default:               enc_nxt.bytes[n] = 8'hFF;
        endcase
        n = n + 4'd1;
        enc_nxt.bytes[n] = {2'b10, rf, r2[2:0]}; n = n + 4'd1;
        if (r2[2:0] == 3'd4) begin
          enc_nxt.bytes[n] = x86e_pkg::SibSp; n = n + 4'd1;
        end
        for (int i = 0; i < 4; i++) begin
          enc_nxt.bytes[n] = in_data.offset_value[8*i +: 8]; n = n + 4'd1;
        end
        if (w) begin
          for (int i = 0; i < 4; i++) begin
            enc_nxt.bytes[n] = in_data.imm_value[8*i +: 8]; n = n + 4'd1;
          end
        end
      end
      x86e_pkg::FnMovEsp, x86e_pkg::FnXchgEsp: begin
        if (!long_mode) begin
          disp8 = 8'd28 - {2'b00, r1, 2'b00};
          enc_nxt.bytes[0] = (in_data.func == x86e_pkg::FnXchgEsp) ? 8'h87
                                                                    : x86e_pkg::OpStore;
          enc_nxt.bytes[1] = 8'h44;
          enc_nxt.bytes[2] = 8'h24;
          enc_nxt.bytes[3] = disp8;
          n = 4'd4;
        end
      end
      x86e_pkg::FnPushf: begin enc_nxt.bytes[0] = 8'h9C; n = 4'd1; end
      x86e_pkg::FnPopf: begin enc_nxt.bytes[0] = 8'h9D; n = 4'd1; end
      x86e_pkg::FnAddImm8, x86e_pkg::FnNeg: begin
        if (long_mode) begin
          enc_nxt.bytes[n] = x86e_pkg::RexW | (r1[3] ? x86e_pkg::RexB : 8'h00);
          n = n + 4'd1;
        end
        if (in_data.func == x86e_pkg::FnAddImm8) begin
          enc_nxt.bytes[n] = 8'h83; n = n + 4'd1;
          enc_nxt.bytes[n] = {5'b11000, r1[2:0]}; n = n + 4'd1;
          enc_nxt.bytes[n] = in_data.imm_value[7:0]; n = n + 4'd1;
        end else begin
          enc_nxt.bytes[n] = 8'hF7; n = n + 4'd1;
          enc_nxt.bytes[n] = {5'b11011, r1[2:0]}; n = n + 4'd1;
        end
      end
      x86e_pkg::FnAddBx: begin
        if (long_mode) begin enc_nxt.bytes[n] = x86e_pkg::RexW; n = n + 4'd1; end
        enc_nxt.bytes[n] = 8'h03; n = n + 4'd1;
        enc_nxt.bytes[n] = 8'hC3; n = n + 4'd1;
      end
      x86e_pkg::FnMovzx: begin
        if (long_mode) begin enc_nxt.bytes[n] = x86e_pkg::RexW; n = n + 4'd1; end
        enc_nxt.bytes[n] = 8'h0F; n = n + 4'd1;
        enc_nxt.bytes[n] = 8'hB6; n = n + 4'd1;
        enc_nxt.bytes[n] = 8'hC0; n = n + 4'd1;
      end
      x86e_pkg::FnUd2: begin
        enc_nxt.bytes[0] = 8'h0F; enc_nxt.bytes[1] = 8'h0B; n = 4'd2;
      end
      default: n = 4'd0;
    endcase
    enc_nxt.len = n;
    // forms with no bytes are dropped here
    vld_nxt = in_valid && (n != 4'd0);
  end

  // registered classification result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    enc_r <= enc_nxt;
  end

  assign enc_data  = enc_r;
  assign enc_valid = vld_r;
endmodule
`default_nettype wire

@@ rtl/core/x86e_back.sv @@
// back end: instruction queue and byte serializer
`default_nettype none
`include "x86_instruction_encoder_macros.svh"
module x86e_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            enc_valid,
  input  wire x86e_pkg::enc_t  enc_data,
  output logic                 q_room,
  output logic                 out_strobe,
  output x86e_pkg::out_item_t  out_data
);
  localparam int QW = $clog2(x86e_pkg::QDepth);

  x86e_pkg::enc_t  q_mem [x86e_pkg::QDepth];
  logic [QW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QW:0]     cnt_r, cnt_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic            pop;
  x86e_pkg::enc_t  head;
  x86e_pkg::out_item_t od_r, od_nxt;
  logic            os_r, os_nxt;

  assign head = q_mem[rp_r];

  // serialize head entry one byte per cycle
  always_comb begin
    logic last;
    last    = (idx_r + 4'd1 == head.len);
    pop     = (cnt_r != '0) && last;
    os_nxt  = (cnt_r != '0);
    od_nxt.out_byte   = head.bytes[idx_r];
    od_nxt.byte_index = idx_r;
    od_nxt.last_byte  = last;
    idx_nxt = (cnt_r == '0) ? idx_r : (last ? 4'd0 : idx_r + 4'd1);
    wp_nxt  = enc_valid ? wp_r + QW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QW'(1) : rp_r;
    cnt_nxt = cnt_r + (QW+1)'(enc_valid) - (QW+1)'(pop);
  end

  // front keeps one item in flight, so two free slots are needed
  assign q_room = (cnt_r <= (QW+1)'(x86e_pkg::QDepth - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      idx_r <= 4'd0;
      os_r  <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      os_r  <= os_nxt;
    end
    od_r <= od_nxt;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (enc_valid) q_mem[wp_r] <= enc_data;
  end

  assign out_strobe = os_r;
  assign out_data   = od_r;

  `X86E_ASSERT_IMP(a_no_overflow, rst_n, cnt_r == (QW+1)'(x86e_pkg::QDepth), !enc_valid)
  `X86E_ASSERT_IMP(a_idx_in_len, rst_n, cnt_r != '0, idx_r < head.len)
  `X86E_ASSERT_NXT(a_last_restarts, rst_n, os_r && od_r.last_byte && cnt_r != '0,
                   idx_r == 4'd1 || out_data.byte_index == 4'd0)
endmodule
`default_nettype wire

@@ rtl/core/x86_instruction_encoder.sv @@
// top level of the x86 instruction encoder
//  channel | ports                         | transfer
//  input   | start, busy, in_data          | start && !busy
//  result  | out_strobe, out_data          | out_strobe, one cycle
//  config  | cfg_we, cfg_wdata             | cfg_we
// an instruction of n bytes leaves one byte a cycle from the serializer,
// and instructions in the queue follow each other with no gap.
// after the transfer, the first byte on an empty queue passes the front register, the
// queue and the output register; forms with no bytes are dropped at the front.
// a four-entry queue between front and serializer absorbs bursts; busy rises when
// it holds three or more instructions. the receiver cannot stall, so busy is the only
// stall. reset is synchronous and sets long mode.
`default_nettype none
module x86_instruction_encoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire x86e_pkg::in_item_t  in_data,
  output logic                     out_strobe,
  output x86e_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);
  logic           mode_r, mode_nxt;
  logic           room;
  logic           enc_valid;
  x86e_pkg::enc_t enc_data;

  // mode register
  always_comb mode_nxt = cfg_we ? cfg_wdata : mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b1;
    else mode_r <= mode_nxt;
  end

  assign busy = !room;

  x86e_front u_front (
    .clk(clk), .rst_n(rst_n), .long_mode(mode_r),
    .in_valid(start && !busy), .in_data(in_data),
    .enc_data(enc_data), .enc_valid(enc_valid)
  );

  x86e_back u_back (
    .clk(clk), .rst_n(rst_n), .enc_valid(enc_valid), .enc_data(enc_data),
    .q_room(room), .out_strobe(out_strobe), .out_data(out_data)
  );
endmodule
`default_nettype wire

@@ tb/sv/x86_instruction_encoder_test.sv @@
// self-checking testbench for the x86 instruction encoder
`timescale 1ns / 1ps
`default_nettype none

// expected byte stream and mismatch bookkeeping
class byte_scoreboard;
  x86e_pkg::out_item_t pending[$];
  int unsigned mismatches;
  int unsigned bytes_seen;
  int unsigned instr_count;
  bit long_mode;

  function new();
    mismatches = 0;
    bytes_seen = 0;
    instr_count = 0;
    long_mode = 1'b1;
  endfunction

  // queue helpers for building one instruction
  local logic [7:0] enc[$];

  local function void put8(logic [7:0] v);
    if (enc.size() < x86e_pkg::MaxBytes) enc.push_back(v);
  endfunction

  local function void put32(logic [31:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
    put8(v[23:16]);
    put8(v[31:24]);
  endfunction

  local function logic [7:0] modrm(int md, int r, int rm);
    return 8'(((md & 3) << 6) | ((r & 7) << 3) | (rm & 7));
  endfunction

  // rex prefix; r and b are register codes, negative when unused
  local function void put_rex(bit w, int r, int b);
    logic [7:0] v;
    v = 8'h00;
    if (!long_mode) return;
    if (w) v |= x86e_pkg::RexW;
    if (r >= 8) v |= x86e_pkg::RexR;
    if (b >= 8) v |= x86e_pkg::RexB;
    if (v != 8'h00) put8(v);
  endfunction

  local function void put_mem(logic [3:0] base, int r, bit d8, logic [31:0] off);
    put8(modrm(d8 ? 1 : 2, r, int'(base)));
    if (base[2:0] == 3'd4) put8(x86e_pkg::SibSp);
    if (d8) put8(off[7:0]);
    else put32(off);
  endfunction

  local function void put_mov_lea(x86e_pkg::in_item_t it, bit is_lea);
    logic [31:0] disp;
    logic [7:0] v;
    disp = it.offset_value;
    if (long_mode) begin
      v = it.src_rex | x86e_pkg::RexRWX;
      if (it.first_reg < 8) v &= x86e_pkg::RexNoR;
      put8(v);
      if (it.src_rip_relative) disp = 32'h0;
    end
    put8(is_lea ? x86e_pkg::OpLea : x86e_pkg::OpLoad);
    put8(modrm(int'(it.src_modrm[7:6]), int'(it.first_reg), int'(it.src_modrm[2:0])));
    if (it.src_sib_present) put8(it.src_sib);
    if (it.src_disp_size == 2'd1) put8(disp[7:0]);
    else if (it.src_disp_size == 2'd2) put32(disp);
  endfunction

  // note an accepted instruction and queue its bytes
  function void note_instruction(x86e_pkg::in_item_t it);
    int r1, r2;
    logic [31:0] slot;
    x86e_pkg::out_item_t o;
    r1 = it.first_reg;
    r2 = it.second_reg;
    slot = long_mode ? 32'd8 : 32'd4;
    enc.delete();
    instr_count++;
    case (it.func)
      x86e_pkg::FnMovRR: begin
        put_rex(1, r1, r2); put8(x86e_pkg::OpStore); put8(modrm(3, r1, r2));
      end
      x86e_pkg::FnStoreSlot, x86e_pkg::FnLoadSlot: begin
        put_rex(1, r1, r2);
        put8(it.func == x86e_pkg::FnLoadSlot ? x86e_pkg::OpLoad : x86e_pkg::OpStore);
        put_mem(it.second_reg, r1, 1, r1 * slot);
      end
      x86e_pkg::FnLea: put_mov_lea(it, 1);
      x86e_pkg::FnMovExpr: put_mov_lea(it, 0);
      x86e_pkg::FnPush: begin put_rex(0, -1, r1); put8(8'h50 + r1[2:0]); end
      x86e_pkg::FnPop: begin put_rex(0, -1, r1); put8(8'h58 + r1[2:0]); end
      x86e_pkg::FnCall: begin put8(x86e_pkg::OpCall); put32(0); end
      x86e_pkg::FnCallReg: begin put_rex(0, -1, r1); put8(8'hFF); put8(modrm(3, 2, r1)); end
      x86e_pkg::FnSubImm: begin put_rex(1, -1, -1); put8(8'h2D); put32(it.imm_value); end
      x86e_pkg::FnCmpImm: begin put_rex(1, -1, -1); put8(8'h3D); put32(it.imm_value); end
      x86e_pkg::FnJcc: begin put8(8'h0F); put8(8'h80 + it.cond_code); put32(0); end
      x86e_pkg::FnRet: put8(8'hC3);
      x86e_pkg::FnXchgSp: begin
        put_rex(1, -1, -1); put8(8'h87); put8(8'h04); put8(8'h24);
      end
      x86e_pkg::FnMovImm: begin
        if (long_mode) begin put8(8'h48); put8(x86e_pkg::OpMovI); put8(8'hC0); end
        else put8(8'hB8);
        put32(it.imm_value);
      end
      x86e_pkg::FnMovImmMem, x86e_pkg::FnOrImmMem: begin
        put_rex(1, -1, r2);
        put8(it.func == x86e_pkg::FnMovImmMem ? x86e_pkg::OpMovI : 8'h81);
        put_mem(it.second_reg, it.func == x86e_pkg::FnMovImmMem ? 0 : 1, 0,
                it.offset_value);
        put32(it.imm_value);
      end
      x86e_pkg::FnTest: begin put_rex(1, r1, r1); put8(8'h85); put8(modrm(3, r1, r1)); end
      x86e_pkg::FnJmpInner, x86e_pkg::FnJmpExt: begin put8(8'hE9); put32(0); end
      x86e_pkg::FnMovEsp, x86e_pkg::FnXchgEsp: begin
        if (!long_mode) begin
          put8(it.func == x86e_pkg::FnXchgEsp ? 8'h87 : 8'h89);
          put8(8'h44);
          put8(8'h24);
          put8(8'((7 - r1) * 4));
        end
      end
      x86e_pkg::FnJmpMem: begin
        put_rex(0, -1, r2); put8(8'hFF); put_mem(it.second_reg, 4, 0, it.offset_value);
      end
      x86e_pkg::FnXchg: begin put_rex(1, r1, r2); put8(8'h87); put8(modrm(3, r1, r2)); end
      x86e_pkg::FnPushf: put8(8'h9C);
      x86e_pkg::FnPopf: put8(8'h9D);
      x86e_pkg::FnSub: begin put_rex(1, r1, r2); put8(8'h29); put8(modrm(3, r1, r2)); end
      x86e_pkg::FnAddImm8: begin
        put_rex(1, -1, r1); put8(8'h83); put8(modrm(3, 0, r1)); put8(it.imm_value[7:0]);
      end
      x86e_pkg::FnNeg: begin put_rex(1, -1, r1); put8(8'hF7); put8(modrm(3, 3, r1)); end
      x86e_pkg::FnAddSlot: begin
        put_rex(1, 0, r2); put8(8'h03); put_mem(it.second_reg, 0, 1, 3 * slot);
      end
      x86e_pkg::FnAddBx: begin put_rex(1, 0, 3); put8(8'h03); put8(modrm(3, 0, 3)); end
      x86e_pkg::FnMovzx: begin
        put_rex(1, 0, 0); put8(8'h0F); put8(8'hB6); put8(modrm(3, 0, 0));
      end
      x86e_pkg::FnUd2: begin put8(8'h0F); put8(8'h0B); end
      default: ;
    endcase
    foreach (enc[k]) begin
      o.out_byte = enc[k];
      o.byte_index = 4'(k);
      o.last_byte = (k == enc.size() - 1);
      pending.push_back(o);
    end
  endfunction

  // compare one emitted byte against the oldest expectation
  function void check_byte(x86e_pkg::out_item_t got);
    x86e_pkg::out_item_t exp_b;
    bytes_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected byte %h idx %0d last %0b",
                                     got.out_byte, got.byte_index, got.last_byte);
      return;
    end
    exp_b = pending.pop_front();
    if (got !== exp_b) begin
      mismatches++;
      if (mismatches <= 10)
        $display("byte mismatch: exp %h/%0d/%0b got %h/%0d/%0b", exp_b.out_byte,
                 exp_b.byte_index, exp_b.last_byte, got.out_byte, got.byte_index,
                 got.last_byte);
    end
  endfunction
endclass

module x86_instruction_encoder_test;
  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  x86e_pkg::in_item_t in_data = '0;
  logic out_strobe;
  x86e_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  byte_scoreboard sb;
  int unsigned idle_cycles = 0;
  bit allow_gaps = 1'b1;

  always #5 clk = ~clk;

  x86_instruction_encoder dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_byte(out_data);
      if (out_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("x86_instruction_encoder_test failed");
        $finish;
      end
    end
  end

  // one instruction transfer, with an optional gap before it
  task automatic send_instr(x86e_pkg::in_item_t it);
    if (allow_gaps && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_instruction(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(bit lm);
    cfg_we <= 1'b1;
    cfg_wdata <= lm;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.long_mode = lm;
  endtask

  function automatic x86e_pkg::in_item_t rand_instr();
    x86e_pkg::in_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(x86e_pkg::in_item_t)-1:0];
    it.func = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(33, 63))
                                           : 6'($urandom_range(0, 32));
    if ($urandom_range(0, 3) == 0) it.imm_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 0;
    return it;
  endfunction

  // directed pass through every form, plus one undefined selector
  task automatic run_directed();
    x86e_pkg::in_item_t it;
    for (int f = 0; f < 34; f++) begin
      it = '0;
      it.func = (f == 33) ? 6'd63 : 6'(f);
      it.first_reg = (f % 2) ? 4'hF : 4'h4;
      it.second_reg = (f % 3) ? 4'hC : 4'h4;
      it.imm_value = (f % 2) ? 32'hFFFF_FFFF : 32'h8000_0001;
      it.offset_value = 32'h1234_56F0;
      it.cond_code = 4'(f);
      it.src_rex = (f % 2) ? 8'hFF : 8'h00;
      it.src_modrm = 8'(f * 37);
      it.src_sib = 8'hA5;
      it.src_sib_present = f[1];
      it.src_disp_size = 2'(f);
      it.src_rip_relative = f[2];
      send_instr(it);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(1'b1);
    run_directed();
    drain();
    write_mode(1'b0);
    run_directed();
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      allow_gaps = (ph != 3);
      repeat (11) send_instr(rand_instr());
      drain();
    end
    $display("covered %0d instructions, %0d bytes, both 32- and 64-bit modes",
             sb.instr_count, sb.bytes_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("x86_instruction_encoder_test passed");
    else
      $display("x86_instruction_encoder_test failed");
    $finish;
  end
endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/x86e_pkg.sv
rtl/core/x86e_front.sv
rtl/core/x86e_back.sv
rtl/core/x86_instruction_encoder.sv
tb/sv/x86_instruction_encoder_test.sv
